// ===== rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned RADIUS_W = 31;
    localparam int unsigned WIDE_W = 36;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic [RADIUS_W-1:0] ra;
        logic [COORD_W-1:0] s;
        logic [COORD_W-1:0] dxm;
        logic [COORD_W-1:0] dym;
        logic dxn;
        logic dyn;
        logic hit;
        logic zero;
        logic [2*COORD_W-1:0] dsq;
    } t_item;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > WIDE_W'(signed'(64'sd2147483647))) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -WIDE_W'(signed'(64'sd2147483648))) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ccc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ccc_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [30:0] first_radius;
    logic [30:0] second_radius;

    modport source (output valid, first_x, first_y, second_x, second_y,
                    first_radius, second_radius, input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y,
                  first_radius, second_radius, output ready);
endinterface

interface ccc_out_if;
    logic valid;
    logic ready;
    logic hit;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] depth_x;
    logic signed [31:0] depth_y;
    logic signed [31:0] touch_x;
    logic signed [31:0] touch_y;

    modport source (output valid, hit, normal_x, normal_y, depth_x, depth_y,
                    touch_x, touch_y, input ready);
    modport sink (input valid, hit, normal_x, normal_y, depth_x, depth_y,
                  touch_x, touch_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/circle_circle_contact.sv =====
// Contact manifold for two circles, fully pipelined.
// The input channel takes one item per cycle while the pipeline is not full:
// the two centres in signed Q16.16 and the two radii in unsigned Q15.16. The
// output channel returns one item for each input item, in order: the hit flag,
// a unit normal in Q1.30, the penetration vector and the contact point in
// Q16.16, saturated. A miss returns all fields zero. An item passes the front
// registers for the differences, the squares and the hit test, 32 square root
// cells with one root bit each, NORMAL_FRAC_BITS + 1 divider cells with one
// quotient bit of both normal components each, then the product register and
// the output register, with the rounding between them. Throughput is one item
// per clock while the receiver takes every output item.
// Every cell has its own valid bit and ready is passed back cell by cell, so
// when the receiver stalls the empty cells keep filling and input items are
// still taken until the whole chain is full. Reset clears all valid bits and
// the block is ready again right after it.
`timescale 1ns / 1ps
`default_nettype none

module circle_circle_contact
    import ccc_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ccc_in_if.sink     i_in,
    ccc_out_if.source  o_out
);

    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int NW = NORMAL_FRAC_BITS + 33;

    logic        s_v    [0:32];
    logic        s_r    [0:32];
    t_item       s_item [0:32];
    logic [31:0] s_root [0:32];
    logic [33:0] s_rem  [0:32];

    logic          d_v    [0:QW];
    logic          d_r    [0:QW];
    t_item         d_item [0:QW];
    logic [31:0]   d_dist [0:QW];
    logic [NW-1:0] d_nx   [0:QW];
    logic [NW-1:0] d_ny   [0:QW];
    logic [31:0]   d_rx   [0:QW];
    logic [31:0]   d_ry   [0:QW];
    logic [QW-1:0] d_qx   [0:QW];
    logic [QW-1:0] d_qy   [0:QW];

    ccc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (s_v[0]),
        .i_ready (s_r[0]),
        .o_item  (s_item[0])
    );

    assign s_root[0] = '0;
    assign s_rem[0]  = '0;

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        ccc_sqrt_cell #(.BIT(31 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[k]),
            .o_ready (s_r[k]),
            .i_item  (s_item[k]),
            .i_root  (s_root[k]),
            .i_rem   (s_rem[k]),
            .o_valid (s_v[k+1]),
            .i_ready (s_r[k+1]),
            .o_item  (s_item[k+1]),
            .o_root  (s_root[k+1]),
            .o_rem   (s_rem[k+1])
        );
    end

    assign d_v[0]    = s_v[32];
    assign s_r[32]   = d_r[0];
    assign d_item[0] = s_item[32];
    assign d_dist[0] = s_root[32];
    assign d_nx[0]   = {1'b0, s_item[32].dxm, {NORMAL_FRAC_BITS{1'b0}}}
                       + NW'(s_root[32] >> 1);
    assign d_ny[0]   = {1'b0, s_item[32].dym, {NORMAL_FRAC_BITS{1'b0}}}
                       + NW'(s_root[32] >> 1);
    assign d_rx[0]   = d_nx[0][NW-1:QW];
    assign d_ry[0]   = d_ny[0][NW-1:QW];
    assign d_qx[0]   = '0;
    assign d_qy[0]   = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        ccc_div_cell #(.NW(NW), .QW(QW), .J(QW - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_v[k]),
            .o_ready (d_r[k]),
            .i_item  (d_item[k]),
            .i_dist  (d_dist[k]),
            .i_num_x (d_nx[k]),
            .i_num_y (d_ny[k]),
            .i_rem_x (d_rx[k]),
            .i_rem_y (d_ry[k]),
            .i_q_x   (d_qx[k]),
            .i_q_y   (d_qy[k]),
            .o_valid (d_v[k+1]),
            .i_ready (d_r[k+1]),
            .o_item  (d_item[k+1]),
            .o_dist  (d_dist[k+1]),
            .o_num_x (d_nx[k+1]),
            .o_num_y (d_ny[k+1]),
            .o_rem_x (d_rx[k+1]),
            .o_rem_y (d_ry[k+1]),
            .o_q_x   (d_qx[k+1]),
            .o_q_y   (d_qy[k+1])
        );
    end

    ccc_back #(.NF(NORMAL_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_v[QW]),
        .o_ready (d_r[QW]),
        .i_item  (d_item[QW]),
        .i_dist  (d_dist[QW]),
        .i_q_x   (d_qx[QW]),
        .i_q_y   (d_qy[QW]),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/ccc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccc_front
    import ccc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    ccc_in_if.sink i_in,
    output logic  o_valid,
    input  wire   i_ready,
    output t_item o_item
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    logic signed [31:0] r1_ax, r1_ay;
    logic [30:0] r1_ra;
    logic [31:0] r1_s;
    logic signed [32:0] r1_dx, r1_dy;

    logic signed [31:0] r2_ax, r2_ay;
    logic [30:0] r2_ra;
    logic [31:0] r2_s;
    logic [31:0] r2_dxm, r2_dym;
    logic r2_dxn, r2_dyn;
    logic [63:0] r2_sx, r2_sy, r2_ss;

    t_item r_item;

    logic signed [32:0] n_dx, n_dy;
    logic [32:0] n_dxa, n_dya;
    logic [64:0] n_dsq;

    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    assign n_dx = {i_in.second_x[31], i_in.second_x} - {i_in.first_x[31], i_in.first_x};
    assign n_dy = {i_in.second_y[31], i_in.second_y} - {i_in.first_y[31], i_in.first_y};
    assign n_dxa = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
    assign n_dya = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);
    assign n_dsq = {1'b0, r2_sx} + {1'b0, r2_sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_ax <= i_in.first_x;
            r1_ay <= i_in.first_y;
            r1_ra <= i_in.first_radius;
            r1_s  <= {1'b0, i_in.first_radius} + {1'b0, i_in.second_radius};
            r1_dx <= n_dx;
            r1_dy <= n_dy;
        end
        if (en2) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_ra  <= r1_ra;
            r2_s   <= r1_s;
            r2_dxm <= n_dxa[31:0];
            r2_dym <= n_dya[31:0];
            r2_dxn <= r1_dx[32];
            r2_dyn <= r1_dy[32];
            r2_sx  <= n_dxa[31:0] * n_dxa[31:0];
            r2_sy  <= n_dya[31:0] * n_dya[31:0];
            r2_ss  <= r1_s * r1_s;
        end
        if (en3) begin
            r_item.ax   <= r2_ax;
            r_item.ay   <= r2_ay;
            r_item.ra   <= r2_ra;
            r_item.s    <= r2_s;
            r_item.dxm  <= r2_dxm;
            r_item.dym  <= r2_dym;
            r_item.dxn  <= r2_dxn;
            r_item.dyn  <= r2_dyn;
            r_item.hit  <= n_dsq < {1'b0, r2_ss};
            r_item.zero <= n_dsq == 65'd0;
            r_item.dsq  <= n_dsq[63:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/ccc_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccc_sqrt_cell
    import ccc_pkg::*;
#(
    parameter int BIT = 31
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  wire  [31:0] i_root,
    input  wire  [33:0] i_rem,
    output logic        o_valid,
    input  wire         i_ready,
    output t_item       o_item,
    output logic [31:0] o_root,
    output logic [33:0] o_rem
);

    logic r_valid;
    logic en;
    t_item r_item;
    logic [31:0] r_root;
    logic [33:0] r_rem;
    logic [35:0] n_acc, n_trial, n_diff;
    logic n_take;

    assign en = !r_valid || i_ready;
    assign o_ready = en;

    assign n_acc   = {i_rem, i_item.dsq[2*BIT+1 -: 2]};
    assign n_trial = {2'b00, i_root, 2'b01};
    assign n_take  = n_acc >= n_trial;
    assign n_diff  = n_acc - n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item <= i_item;
            r_root <= {i_root[30:0], n_take};
            r_rem  <= n_take ? n_diff[33:0] : n_acc[33:0];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_root  = r_root;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

// ===== rtl/ccc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccc_div_cell
    import ccc_pkg::*;
#(
    parameter int NW = 63,
    parameter int QW = 31,
    parameter int J  = 30
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  t_item         i_item,
    input  wire  [31:0]   i_dist,
    input  wire  [NW-1:0] i_num_x,
    input  wire  [NW-1:0] i_num_y,
    input  wire  [31:0]   i_rem_x,
    input  wire  [31:0]   i_rem_y,
    input  wire  [QW-1:0] i_q_x,
    input  wire  [QW-1:0] i_q_y,
    output logic          o_valid,
    input  wire           i_ready,
    output t_item         o_item,
    output logic [31:0]   o_dist,
    output logic [NW-1:0] o_num_x,
    output logic [NW-1:0] o_num_y,
    output logic [31:0]   o_rem_x,
    output logic [31:0]   o_rem_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y
);

    logic r_valid;
    logic en;
    t_item r_item;
    logic [31:0] r_dist, r_rem_x, r_rem_y;
    logic [NW-1:0] r_num_x, r_num_y;
    logic [QW-1:0] r_q_x, r_q_y, n_q_x, n_q_y;
    logic [32:0] n_ax, n_ay, n_dx, n_dy;
    logic n_tx, n_ty;

    assign en = !r_valid || i_ready;
    assign o_ready = en;

    assign n_ax = {i_rem_x, i_num_x[J]};
    assign n_ay = {i_rem_y, i_num_y[J]};
    assign n_tx = n_ax >= {1'b0, i_dist};
    assign n_ty = n_ay >= {1'b0, i_dist};
    assign n_dx = n_ax - {1'b0, i_dist};
    assign n_dy = n_ay - {1'b0, i_dist};

    always_comb begin
        n_q_x = i_q_x;
        n_q_y = i_q_y;
        n_q_x[J] = n_tx;
        n_q_y[J] = n_ty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item  <= i_item;
            r_dist  <= i_dist;
            r_num_x <= i_num_x;
            r_num_y <= i_num_y;
            r_rem_x <= n_tx ? n_dx[31:0] : n_ax[31:0];
            r_rem_y <= n_ty ? n_dy[31:0] : n_ay[31:0];
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_dist  = r_dist;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;

endmodule

`default_nettype wire

// ===== rtl/ccc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccc_back
    import ccc_pkg::*;
#(
    parameter int NF = 30
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  t_item        i_item,
    input  wire  [31:0]  i_dist,
    input  wire  [NF:0]  i_q_x,
    input  wire  [NF:0]  i_q_y,
    ccc_out_if.source    o_out
);

    localparam int PW = 32 + NF + 1;

    logic r_vm, r_vo;
    logic en_m, en_o;

    logic signed [31:0] r_ax, r_ay;
    logic [30:0] r_ra;
    logic r_dxn, r_dyn, r_hit, r_zero;
    logic [NF:0] r_q_x, r_q_y;
    logic [PW-1:0] r_pdx, r_pdy, r_ptx, r_pty;

    logic r_hit_o;
    logic signed [31:0] r_nx, r_ny, r_px, r_py, r_tx, r_ty;

    logic [31:0] n_overlap;
    logic signed [WIDE_W-1:0] n_sdx, n_sdy, n_stx, n_sty;
    logic signed [31:0] n_nx, n_ny, n_px, n_py, n_tx, n_ty;

    function automatic logic signed [WIDE_W-1:0] round_sign(input logic [PW-1:0] p,
                                                            input logic neg);
        logic [PW:0] t;
        logic signed [WIDE_W-1:0] m;
        t = {1'b0, p} + ((PW+1)'(1) << (NF - 1));
        m = signed'({2'b00, t[NF+33:NF]});
        return neg ? -m : m;
    endfunction

    assign en_o = !r_vo || o_out.ready;
    assign en_m = !r_vm || en_o;
    assign o_ready = en_m;

    assign n_overlap = i_item.s - i_dist;

    assign n_sdx = round_sign(r_pdx, r_dxn);
    assign n_sdy = round_sign(r_pdy, r_dyn);
    assign n_stx = round_sign(r_ptx, r_dxn);
    assign n_sty = round_sign(r_pty, r_dyn);

    always_comb begin
        if (!r_hit) begin
            n_nx = '0;
            n_ny = '0;
            n_px = '0;
            n_py = '0;
            n_tx = '0;
            n_ty = '0;
        end else if (r_zero) begin
            n_nx = 32'sd1 <<< NF;
            n_ny = '0;
            n_px = signed'({1'b0, r_ra});
            n_py = '0;
            n_tx = r_ax;
            n_ty = r_ay;
        end else begin
            n_nx = r_dxn ? -signed'(32'(r_q_x)) : signed'(32'(r_q_x));
            n_ny = r_dyn ? -signed'(32'(r_q_y)) : signed'(32'(r_q_y));
            n_px = sat32(n_sdx);
            n_py = sat32(n_sdy);
            n_tx = sat32(WIDE_W'(r_ax) + n_stx);
            n_ty = sat32(WIDE_W'(r_ay) + n_sty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_m) begin
                r_vm <= i_valid;
            end
            if (en_o) begin
                r_vo <= r_vm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_ax   <= i_item.ax;
            r_ay   <= i_item.ay;
            r_ra   <= i_item.ra;
            r_dxn  <= i_item.dxn;
            r_dyn  <= i_item.dyn;
            r_hit  <= i_item.hit;
            r_zero <= i_item.zero;
            r_q_x  <= i_q_x;
            r_q_y  <= i_q_y;
            r_pdx  <= n_overlap * i_q_x;
            r_pdy  <= n_overlap * i_q_y;
            r_ptx  <= i_item.ra * i_q_x;
            r_pty  <= i_item.ra * i_q_y;
        end
        if (en_o) begin
            r_hit_o <= r_hit;
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_px <= n_px;
            r_py <= n_py;
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
    end

    assign o_out.valid    = r_vo;
    assign o_out.hit      = r_hit_o;
    assign o_out.normal_x = r_nx;
    assign o_out.normal_y = r_ny;
    assign o_out.depth_x  = r_px;
    assign o_out.depth_y  = r_py;
    assign o_out.touch_x  = r_tx;
    assign o_out.touch_y  = r_ty;

endmodule

`default_nettype wire

// ===== rtl/ccc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccc_checker #(
    parameter int NORMAL_FRAC_BITS = 30
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire               i_hit,
    input wire signed [31:0] i_normal_x,
    input wire signed [31:0] i_normal_y,
    input wire signed [31:0] i_depth_x,
    input wire signed [31:0] i_depth_y,
    input wire signed [31:0] i_touch_x,
    input wire signed [31:0] i_touch_y
);

    localparam logic signed [31:0] UNIT = 32'sd1 <<< NORMAL_FRAC_BITS;

    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_normal_x)
            && $stable(i_depth_x) && $stable(i_touch_y))
        else $error("stalled output item changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_normal_x == 0 && i_normal_y == 0
            && i_depth_x == 0 && i_depth_y == 0 && i_touch_x == 0 && i_touch_y == 0)
        else $error("miss with nonzero fields");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> i_normal_x <= UNIT && i_normal_x >= -UNIT
            && i_normal_y <= UNIT && i_normal_y >= -UNIT)
        else $error("normal component out of range");

endmodule

bind circle_circle_contact ccc_checker #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_ccc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hit       (o_out.hit),
    .i_normal_x  (o_out.normal_x),
    .i_normal_y  (o_out.normal_y),
    .i_depth_x   (o_out.depth_x),
    .i_depth_y   (o_out.depth_y),
    .i_touch_x   (o_out.touch_x),
    .i_touch_y   (o_out.touch_y)
);

`default_nettype wire
